>>> design/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// shared codes, field widths and state type for the page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

   // fixed field widths
   localparam int ACTION_W   = 3;
   localparam int ADDR_W     = 27;
   localparam int CVAL_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int REF_W      = 8;
   localparam int PAGE_SHIFT = 12;
   localparam int PGNUM_W    = ADDR_W - PAGE_SHIFT;
   localparam int CFG_W      = 15;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INC   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SET   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd2;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

endpackage : rpa_pkg

`default_nettype wire

>>> design/rpa_ram.sv
// ----------------------------------------------------------------------------
// rpa_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : rpa_ram

`default_nettype wire

>>> design/refcounted_page_allocator_top.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator_top
// page allocator with a lifo free stack and per-page reference counts
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   action, addr, count_value
//   rsp       out        rsp_valid / rsp_ready   status, page_addr, ref_count_out,
//                                                single_owner, page_released
//   csr       in         csr_wr_en (no wait)     first_usable_page
//
// - accept issues the reads of the count ram and the stack ram; in S_EXEC the
//   block then does modify and write-back of both once the result register is free
// - a new request is taken only in S_IDLE, after the write-back of the last one
// - after reset a clearing pass writes zero to every count, during which
//   req_ready stays low; csr writes are taken at any time
// - the result register lets a new request in while a result waits; the
//   write-back stalls only while that register is full and rsp_ready is low
//
`default_nettype none

module refcounted_page_allocator_top #(
   parameter int NUM_PAGES  = 32768,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [rpa_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [rpa_pkg::ADDR_W-1:0]     req_addr,
   input  wire logic [rpa_pkg::CVAL_W-1:0]     req_count_value,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [rpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [rpa_pkg::ADDR_W-1:0]     rsp_page_addr,
   output logic      [rpa_pkg::REF_W-1:0]      rsp_ref_count_out,
   output logic                                rsp_single_owner,
   output logic                                rsp_page_released,
   // configuration
   input  wire logic                           csr_wr_en,
   input  wire logic [rpa_pkg::CFG_W-1:0]      csr_wr_data
);

   import rpa_pkg::*;

   localparam int PAGE_W  = $clog2(NUM_PAGES);
   localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // control state
   state_type           state_ff, state_in;
   logic [PAGE_W-1:0]   clr_ff, clr_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [CFG_W-1:0]    first_page_ff;

   // captured request
   logic [ACTION_W-1:0] act_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [CVAL_W-1:0]   cval_ff;
   logic                addr_ok_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   page_addr_ff, page_addr_in;
   logic [REF_W-1:0]    ref_ff, ref_in;
   logic                single_ff, single_in;
   logic                released_ff, released_in;

   // ram ports
   logic                  cnt_we, cnt_re;
   logic [PAGE_W-1:0]     cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
   logic                  stk_we, stk_re;
   logic [PAGE_W-1:0]     stk_waddr, stk_raddr;
   logic [PAGE_W-1:0]     stk_wdata, stk_rd;

   // request decode
   logic                  accept;
   logic [PGNUM_W-1:0]    req_page;
   logic                  req_addr_ok;
   logic [DEPTH_W-1:0]    depth_m1;
   logic                  fire;
   logic [COUNT_BITS-1:0] c_new;
   logic                  cval_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // page number and address check, done at accept
   assign req_page    = req_addr[ADDR_W-1:PAGE_SHIFT];
   assign req_addr_ok = (req_addr[PAGE_SHIFT-1:0] == '0)
                        && (req_page >= first_page_ff)
                        && (32'(req_page) < 32'(NUM_PAGES));

   // top of stack sits one below the depth
   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign cnt_re    = accept;
   assign cnt_raddr = PAGE_W'(req_page);
   assign stk_re    = accept;
   assign stk_raddr = depth_m1[PAGE_W-1:0];

   // write-back goes ahead once the result register can take the result
   assign fire     = !rsp_valid_ff || rsp_ready;
   assign cval_sat = (cval_ff >> COUNT_BITS) != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         depth_ff      <= '0;
         first_page_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            first_page_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff     <= req_action;
         page_ff    <= PAGE_W'(req_page);
         cval_ff    <= req_count_value;
         addr_ok_ff <= req_addr_ok;
      end
      status_ff    <= status_in;
      page_addr_ff <= page_addr_in;
      ref_ff       <= ref_in;
      single_ff    <= single_in;
      released_ff  <= released_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      page_addr_in = page_addr_ff;
      ref_in       = ref_ff;
      single_in    = single_ff;
      released_in  = released_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = page_ff;
      cnt_wdata    = '0;
      stk_we       = 1'b0;
      stk_waddr    = depth_ff[PAGE_W-1:0];
      stk_wdata    = page_ff;
      c_new        = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one count per cycle
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + PAGE_W'(1);
            if (clr_ff == PAGE_W'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (fire) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               page_addr_in = '0;
               released_in  = 1'b0;

               if (act_ff == ACT_ALLOC) begin
                  if (depth_ff == '0) begin
                     status_in = ST_NO_MEM;
                  end else begin
                     // pop and give the page one owner
                     depth_in     = depth_m1;
                     cnt_we       = 1'b1;
                     cnt_waddr    = stk_rd;
                     cnt_wdata    = COUNT_BITS'(1);
                     c_new        = COUNT_BITS'(1);
                     page_addr_in = ADDR_W'({stk_rd, {PAGE_SHIFT{1'b0}}});
                  end
               end else if (act_ff > ACT_SET) begin
                  // unused action codes give an empty ok result
                  status_in = ST_OK;
               end else if (!addr_ok_ff) begin
                  status_in = ST_BAD_ADDR;
               end else begin
                  unique case (act_ff)
                     ACT_FREE: begin
                        c_new = (cnt_rd == '0) ? '0 : cnt_rd - COUNT_BITS'(1);
                        if (c_new == '0 && 32'(depth_ff) < 32'(NUM_PAGES)) begin
                           stk_we      = 1'b1;
                           depth_in    = depth_ff + DEPTH_W'(1);
                           released_in = 1'b1;
                        end
                     end
                     ACT_INC: begin
                        c_new = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
                     end
                     ACT_SET: begin
                        c_new = cval_sat ? COUNT_MAX : COUNT_BITS'(cval_ff);
                     end
                     default: begin
                        c_new = cnt_rd;
                     end
                  endcase
                  cnt_we    = (act_ff != ACT_READ);
                  cnt_wdata = c_new;
               end

               // reported count saturates at the output field width
               ref_in    = ((c_new >> REF_W) != '0) ? '1 : REF_W'(c_new);
               single_in = (c_new == COUNT_BITS'(1));
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // reference counts
   rpa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (COUNT_BITS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rd)
   );

   // free page stack
   rpa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (PAGE_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_page_addr     = page_addr_ff;
   assign rsp_ref_count_out = ref_ff;
   assign rsp_single_owner  = single_ff;
   assign rsp_page_released = released_ff;

endmodule : refcounted_page_allocator_top

`default_nettype wire
